/* design/ctc_pkg.sv */
// ----------------------------------------------------------------------------
// ctc_pkg: shared types and constants of the cloth tether constraint
// Field layout of the stream beats, function codes, datapath command and
// status records.
// ----------------------------------------------------------------------------
package ctc_pkg;

   localparam int VERTICES = 1024;
   localparam int IDX_W    = $clog2(VERTICES);
   localparam int STEP_W   = IDX_W + 1;
   localparam int COORD_W  = 32;
   localparam int SCALE_W  = 16;
   localparam int FUNC_W   = 2;
   localparam int NODE_W   = IDX_W + 2;   // {has_parent, parent, fixed}
   localparam int CNT_W    = 6;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

   // request beat layout
   localparam int REQ_DATA_W = 120;
   localparam int RQ_V_LSB   = 0;
   localparam int RQ_X_LSB   = 10;
   localparam int RQ_Y_LSB   = 42;
   localparam int RQ_Z_LSB   = 74;
   localparam int RQ_P_LSB   = 106;
   localparam int RQ_HP_BIT  = 116;
   localparam int RQ_FX_BIT  = 117;

   // response beat layout
   localparam int RSP_DATA_W = 112;
   localparam int RS_CL_BIT  = 106;
   localparam int RS_PAD_W   = RSP_DATA_W - RS_CL_BIT - 1;

   localparam logic [CNT_W-1:0] SQRT_STEPS_M1 = 6'd32;
   localparam logic [CNT_W-1:0] DIV_STEPS_M1  = 6'd31;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_BUILD = 2'd1,
      FUNC_PRED  = 2'd2,
      FUNC_SOLVE = 2'd3
   } func_type;

   typedef enum logic [0:0] {
      KIND_BUILD = 1'b0,
      KIND_SOLVE = 1'b1
   } kind_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD_WR,
      OP_PRED_WR,
      OP_BUILD_INIT,
      OP_TETH_OFF,
      OP_VERT_START,
      OP_TAKE_ROOT,
      OP_ADVANCE,
      OP_SQ,
      OP_SQ_END,
      OP_SQRT,
      OP_ACC,
      OP_LIM_MUL,
      OP_LIM,
      OP_TETH_SET,
      OP_SV_TAKE,
      OP_TAKE_PRED_ROOT,
      OP_DIV_INIT,
      OP_DIV,
      OP_PULL_MUL,
      OP_PULL_ADD,
      OP_PRED_WB,
      OP_EMIT_BUILD,
      OP_EMIT_SOLVE
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] comp;
      logic       rd_root;
      logic       clamp;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     i_skip;
      logic     root_stop;
      logic     i_last;
      logic     cnt_zero;
      logic     tethered;
      logic     need_clamp;
      logic     out_busy;
   } dp_stat_type;

endpackage

/* design/ctc_ctrl.sv */
// ----------------------------------------------------------------------------
// ctc_ctrl: sequencer of the cloth tether constraint
// Steps the datapath through load, predict, build walks and solves.
// ----------------------------------------------------------------------------
module ctc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                take,
   output ctc_pkg::dp_cmd_type cmd,
   input  ctc_pkg::dp_stat_type stat
);
   import ctc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH,
      ST_B_RD_I, ST_B_CHK_I, ST_B_RD_ROOT, ST_B_GOT_ROOT,
      ST_SQ, ST_SQ_END, ST_SQRT,
      ST_B_ACC, ST_B_CHK_ROOT, ST_B_LIM_MUL, ST_B_LIM, ST_B_WR, ST_B_DONE,
      ST_SV_RD, ST_SV_TAKE, ST_SV_RD_ROOT, ST_SV_GOT_ROOT, ST_SV_CMP,
      ST_DIV, ST_PL_MUL, ST_PL_ADD, ST_SV_WB, ST_SV_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] comp_ff, comp_in;
   logic       solve_ff, solve_in;
   logic       clamp_ff, clamp_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign take       = req_tvalid & req_tready;

   always_comb begin
      state_in    = state_ff;
      comp_in     = comp_ff;
      solve_in    = solve_ff;
      clamp_in    = clamp_ff;
      cmd.op      = OP_NOP;
      cmd.comp    = comp_ff;
      cmd.rd_root = 1'b0;
      cmd.clamp   = clamp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (stat.func)
               FUNC_LOAD: begin
                  cmd.op   = OP_LOAD_WR;
                  state_in = ST_IDLE;
               end
               FUNC_PRED: begin
                  cmd.op   = OP_PRED_WR;
                  state_in = ST_IDLE;
               end
               FUNC_BUILD: begin
                  cmd.op   = OP_BUILD_INIT;
                  solve_in = 1'b0;
                  state_in = ST_B_RD_I;
               end
               FUNC_SOLVE: begin
                  solve_in = 1'b1;
                  state_in = ST_SV_RD;
               end
            endcase
         end
         ST_B_RD_I: state_in = ST_B_CHK_I;
         ST_B_CHK_I: begin
            if (stat.i_skip) begin
               cmd.op   = OP_TETH_OFF;
               state_in = stat.i_last ? ST_B_DONE : ST_B_RD_I;
            end else begin
               cmd.op   = OP_VERT_START;
               state_in = ST_B_RD_ROOT;
            end
         end
         ST_B_RD_ROOT: begin
            cmd.rd_root = 1'b1;
            state_in    = ST_B_GOT_ROOT;
         end
         ST_B_GOT_ROOT: begin
            cmd.op   = OP_TAKE_ROOT;
            comp_in  = 2'd0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.op = OP_SQ;
            if (comp_ff == 2'd2) begin
               state_in = ST_SQ_END;
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         ST_SQ_END: begin
            cmd.op   = OP_SQ_END;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = OP_SQRT;
            if (stat.cnt_zero) state_in = solve_ff ? ST_SV_CMP : ST_B_ACC;
         end
         ST_B_ACC: begin
            cmd.op   = OP_ACC;
            state_in = ST_B_CHK_ROOT;
         end
         ST_B_CHK_ROOT: begin
            if (stat.root_stop) begin
               state_in = ST_B_LIM_MUL;
            end else begin
               cmd.op   = OP_ADVANCE;
               state_in = ST_B_RD_ROOT;
            end
         end
         ST_B_LIM_MUL: begin
            cmd.op   = OP_LIM_MUL;
            state_in = ST_B_LIM;
         end
         ST_B_LIM: begin
            cmd.op   = OP_LIM;
            state_in = ST_B_WR;
         end
         ST_B_WR: begin
            cmd.op   = OP_TETH_SET;
            state_in = stat.i_last ? ST_B_DONE : ST_B_RD_I;
         end
         ST_B_DONE: begin
            if (!stat.out_busy) begin
               cmd.op   = OP_EMIT_BUILD;
               state_in = ST_IDLE;
            end
         end
         ST_SV_RD: state_in = ST_SV_TAKE;
         ST_SV_TAKE: begin
            cmd.op   = OP_SV_TAKE;
            clamp_in = 1'b0;
            state_in = stat.tethered ? ST_SV_RD_ROOT : ST_SV_OUT;
         end
         ST_SV_RD_ROOT: begin
            cmd.rd_root = 1'b1;
            state_in    = ST_SV_GOT_ROOT;
         end
         ST_SV_GOT_ROOT: begin
            cmd.op   = OP_TAKE_PRED_ROOT;
            comp_in  = 2'd0;
            state_in = ST_SQ;
         end
         ST_SV_CMP: begin
            if (stat.need_clamp) begin
               cmd.op   = OP_DIV_INIT;
               clamp_in = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_SV_OUT;
            end
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            if (stat.cnt_zero) begin
               comp_in  = 2'd0;
               state_in = ST_PL_MUL;
            end
         end
         ST_PL_MUL: begin
            cmd.op   = OP_PULL_MUL;
            state_in = ST_PL_ADD;
         end
         ST_PL_ADD: begin
            cmd.op = OP_PULL_ADD;
            if (comp_ff == 2'd2) begin
               state_in = ST_SV_WB;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_PL_MUL;
            end
         end
         ST_SV_WB: begin
            cmd.op   = OP_PRED_WB;
            state_in = ST_SV_OUT;
         end
         ST_SV_OUT: begin
            if (!stat.out_busy) begin
               cmd.op   = OP_EMIT_SOLVE;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         comp_ff  <= 2'd0;
         solve_ff <= 1'b0;
         clamp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
         solve_ff <= solve_in;
         clamp_ff <= clamp_in;
      end
   end

endmodule

/* design/ctc_datapath.sv */
// ----------------------------------------------------------------------------
// ctc_datapath: tables and arithmetic of the cloth tether constraint
// Vertex tables, shared multiplier, bit-serial square root and divider,
// result register.
// ----------------------------------------------------------------------------
module ctc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  logic [ctc_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic [ctc_pkg::FUNC_W-1:0]           req_tuser,
   input  logic                                 csr_valid,
   input  logic [ctc_pkg::SCALE_W-1:0]          csr_data,
   input  ctc_pkg::dp_cmd_type                  cmd,
   output ctc_pkg::dp_stat_type                 stat,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [ctc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tuser
);
   import ctc_pkg::*;

   localparam int PT_W = 3 * COORD_W;

   // latched request
   logic [FUNC_W-1:0]  func_ff;
   logic [IDX_W-1:0]   v_ff;
   logic [PT_W-1:0]    pos_ff;
   logic [IDX_W-1:0]   par_ff;
   logic               hp_ff;
   logic               fx_ff;

   logic [SCALE_W-1:0] scale_ff;
   logic               built_ff;

   // tables
   logic [PT_W-1:0]    rest_mem   [VERTICES];
   logic [NODE_W-1:0]  node_mem   [VERTICES];
   logic [IDX_W-1:0]   rootix_mem [VERTICES];
   logic [COORD_W-1:0] limit_mem  [VERTICES];
   logic               teth_mem   [VERTICES];
   logic [PT_W-1:0]    pred_mem   [VERTICES];

   logic [PT_W-1:0]    rest_q, pred_q;
   logic [NODE_W-1:0]  node_q;
   logic [IDX_W-1:0]   rootix_q;
   logic [COORD_W-1:0] limit_q;
   logic               teth_q;

   // working registers
   logic [IDX_W-1:0]          i_ff, root_ff;
   logic [STEP_W-1:0]         steps_ff;
   logic [COORD_W-1:0]        acc_ff, lim_ff, f_ff;
   logic signed [COORD_W-1:0] pa_ff [3];
   logic signed [COORD_W-1:0] pb_ff [3];
   logic [NODE_W-1:0]         rnode_ff;
   logic [2*COORD_W-1:0]      prod_ff;
   logic [2*COORD_W+1:0]      sum_ff;
   logic [COORD_W+2:0]        rem_ff;
   logic [COORD_W:0]          sroot_ff;
   logic [COORD_W+1:0]        drem_ff;
   logic [CNT_W-1:0]          cnt_ff;

   logic                      rsp_valid_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic                      rsp_kind_ff;

   logic [IDX_W-1:0] node_ra, pred_ra;
   assign node_ra = cmd.rd_root ? root_ff : i_ff;
   assign pred_ra = cmd.rd_root ? root_ff : v_ff;

   // component differences pa - pb
   logic [COORD_W:0]   diff [3];
   logic [COORD_W-1:0] mag  [3];
   logic               neg  [3];
   for (genvar c = 0; c < 3; c++) begin : g_diff
      logic [COORD_W:0] ndiff;
      assign diff[c]  = {pa_ff[c][COORD_W-1], pa_ff[c]} - {pb_ff[c][COORD_W-1], pb_ff[c]};
      assign neg[c]   = diff[c][COORD_W];
      assign ndiff    = -diff[c];
      assign mag[c]   = neg[c] ? ndiff[COORD_W-1:0] : diff[c][COORD_W-1:0];
   end

   logic [COORD_W-1:0]        sel_mag;
   logic                      sel_neg;
   logic signed [COORD_W-1:0] sel_pb;
   always_comb begin
      unique case (cmd.comp)
         2'd1: begin
            sel_mag = mag[1]; sel_neg = neg[1]; sel_pb = pb_ff[1];
         end
         2'd2: begin
            sel_mag = mag[2]; sel_neg = neg[2]; sel_pb = pb_ff[2];
         end
         default: begin
            sel_mag = mag[0]; sel_neg = neg[0]; sel_pb = pb_ff[0];
         end
      endcase
   end

   // shared multiplier operands
   logic [COORD_W-1:0] mul_a, mul_b;
   always_comb begin
      unique case (cmd.op)
         OP_SQ: begin
            mul_a = sel_mag;
            mul_b = sel_mag;
         end
         OP_LIM_MUL: begin
            mul_a = acc_ff;
            mul_b = {{(COORD_W-SCALE_W){1'b0}}, scale_ff};
         end
         OP_PULL_MUL: begin
            mul_a = sel_mag;
            mul_b = f_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // square root step
   logic [COORD_W+4:0] sq_rem2, sq_trial, sq_sub;
   logic               sq_ge;
   assign sq_rem2  = {rem_ff, sum_ff[2*COORD_W+1 -: 2]};
   assign sq_trial = {2'b00, sroot_ff, 2'b01};
   assign sq_ge    = (sq_rem2 >= sq_trial);
   assign sq_sub   = sq_rem2 - sq_trial;

   // divide step
   logic [COORD_W+1:0] dv_t, dv_d;
   logic               dv_ge;
   assign dv_t  = {drem_ff[COORD_W:0], 1'b0};
   assign dv_d  = {1'b0, sroot_ff};
   assign dv_ge = (dv_t >= dv_d);

   // accumulate with saturation
   logic [COORD_W+1:0] acc_sum;
   assign acc_sum = {2'b00, acc_ff} + {1'b0, sroot_ff};

   // pull-back add with saturation
   logic signed [COORD_W+1:0] pl_base, pl_off, pl_sum;
   logic [COORD_W-1:0]        pl_res;
   assign pl_base = {{2{sel_pb[COORD_W-1]}}, sel_pb};
   assign pl_off  = {2'b00, prod_ff[2*COORD_W-1:COORD_W]};
   assign pl_sum  = sel_neg ? pl_base - pl_off : pl_base + pl_off;
   always_comb begin
      if (pl_sum[COORD_W+1:COORD_W-1] == 3'b000 || pl_sum[COORD_W+1:COORD_W-1] == 3'b111) begin
         pl_res = pl_sum[COORD_W-1:0];
      end else if (pl_sum[COORD_W+1]) begin
         pl_res = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         pl_res = {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

   logic [PT_W-1:0] pa_word;
   assign pa_word = {pa_ff[2], pa_ff[1], pa_ff[0]};

   // ---------------- tables ----------------
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD_WR) rest_mem[v_ff] <= pos_ff;
      rest_q <= rest_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD_WR) node_mem[v_ff] <= {hp_ff, par_ff, fx_ff};
      node_q <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_TETH_SET) rootix_mem[i_ff] <= root_ff;
      rootix_q <= rootix_mem[v_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_TETH_SET) limit_mem[i_ff] <= lim_ff;
      limit_q <= limit_mem[v_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_TETH_SET || cmd.op == OP_TETH_OFF) begin
         teth_mem[i_ff] <= (cmd.op == OP_TETH_SET);
      end
      teth_q <= teth_mem[v_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_PRED_WR) begin
         pred_mem[v_ff] <= pos_ff;
      end else if (cmd.op == OP_PRED_WB) begin
         pred_mem[v_ff] <= pa_word;
      end
      pred_q <= pred_mem[pred_ra];
   end

   // ---------------- request capture ----------------
   always_ff @(posedge clock) begin
      if (take) begin
         func_ff <= req_tuser;
         v_ff    <= req_tdata[RQ_V_LSB +: IDX_W];
         pos_ff  <= req_tdata[RQ_X_LSB +: PT_W];
         par_ff  <= req_tdata[RQ_P_LSB +: IDX_W];
         hp_ff   <= req_tdata[RQ_HP_BIT];
         fx_ff   <= req_tdata[RQ_FX_BIT];
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_RESET;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) scale_ff <= csr_data;
         if (cmd.op == OP_BUILD_INIT) built_ff <= 1'b1;
         if (cmd.op == OP_EMIT_BUILD || cmd.op == OP_EMIT_SOLVE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- working registers ----------------
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_BUILD_INIT: i_ff <= '0;
         OP_TETH_OFF: i_ff <= i_ff + 1'b1;
         OP_VERT_START: begin
            root_ff  <= node_q[IDX_W:1];
            pa_ff[0] <= rest_q[0 +: COORD_W];
            pa_ff[1] <= rest_q[COORD_W +: COORD_W];
            pa_ff[2] <= rest_q[2*COORD_W +: COORD_W];
            steps_ff <= '0;
            acc_ff   <= '0;
         end
         OP_TAKE_ROOT: begin
            pb_ff[0] <= rest_q[0 +: COORD_W];
            pb_ff[1] <= rest_q[COORD_W +: COORD_W];
            pb_ff[2] <= rest_q[2*COORD_W +: COORD_W];
            rnode_ff <= node_q;
         end
         OP_ADVANCE: begin
            pa_ff[0] <= pb_ff[0];
            pa_ff[1] <= pb_ff[1];
            pa_ff[2] <= pb_ff[2];
            root_ff  <= rnode_ff[IDX_W:1];
            steps_ff <= steps_ff + 1'b1;
         end
         OP_SQ: begin
            prod_ff <= mul_a * mul_b;
            if (cmd.comp == 2'd0) begin
               sum_ff <= '0;
            end else begin
               sum_ff <= sum_ff + {2'b00, prod_ff};
            end
         end
         OP_SQ_END: begin
            sum_ff   <= sum_ff + {2'b00, prod_ff};
            rem_ff   <= '0;
            sroot_ff <= '0;
            cnt_ff   <= SQRT_STEPS_M1;
         end
         OP_SQRT: begin
            rem_ff   <= sq_ge ? sq_sub[COORD_W+2:0] : sq_rem2[COORD_W+2:0];
            sroot_ff <= {sroot_ff[COORD_W-1:0], sq_ge};
            sum_ff   <= {sum_ff[2*COORD_W-1:0], 2'b00};
            cnt_ff   <= cnt_ff - 1'b1;
         end
         OP_ACC: acc_ff <= (|acc_sum[COORD_W+1:COORD_W]) ? '1 : acc_sum[COORD_W-1:0];
         OP_LIM_MUL: prod_ff <= mul_a * mul_b;
         OP_LIM: begin
            // Q8.8 scale: drop eight fraction bits, clip to 32 bits
            lim_ff <= (|prod_ff[2*COORD_W-1:COORD_W+8]) ? '1 : prod_ff[COORD_W+7:8];
         end
         OP_TETH_SET: i_ff <= i_ff + 1'b1;
         OP_SV_TAKE: begin
            pa_ff[0] <= pred_q[0 +: COORD_W];
            pa_ff[1] <= pred_q[COORD_W +: COORD_W];
            pa_ff[2] <= pred_q[2*COORD_W +: COORD_W];
            root_ff  <= rootix_q;
            lim_ff   <= limit_q;
         end
         OP_TAKE_PRED_ROOT: begin
            pb_ff[0] <= pred_q[0 +: COORD_W];
            pb_ff[1] <= pred_q[COORD_W +: COORD_W];
            pb_ff[2] <= pred_q[2*COORD_W +: COORD_W];
         end
         OP_DIV_INIT: begin
            drem_ff <= {2'b00, lim_ff};
            f_ff    <= '0;
            cnt_ff  <= DIV_STEPS_M1;
         end
         OP_DIV: begin
            drem_ff <= dv_ge ? dv_t - dv_d : dv_t;
            f_ff    <= {f_ff[COORD_W-2:0], dv_ge};
            cnt_ff  <= cnt_ff - 1'b1;
         end
         OP_PULL_MUL: prod_ff <= mul_a * mul_b;
         OP_PULL_ADD: begin
            unique case (cmd.comp)
               2'd1: pa_ff[1] <= pl_res;
               2'd2: pa_ff[2] <= pl_res;
               default: pa_ff[0] <= pl_res;
            endcase
         end
         OP_EMIT_BUILD: begin
            rsp_kind_ff <= KIND_BUILD;
            rsp_data_ff <= '0;
         end
         OP_EMIT_SOLVE: begin
            rsp_kind_ff <= KIND_SOLVE;
            rsp_data_ff <= {{RS_PAD_W{1'b0}}, cmd.clamp, pa_word, v_ff};
         end
         default: ;
      endcase
   end

   // ---------------- status ----------------
   always_comb begin
      stat.func       = func_type'(func_ff);
      stat.i_skip     = node_q[0] | ~node_q[NODE_W-1];
      stat.root_stop  = rnode_ff[0] | ~rnode_ff[NODE_W-1]
                        | (steps_ff == STEP_W'(VERTICES));
      stat.i_last     = (i_ff == IDX_W'(VERTICES - 1));
      stat.cnt_zero   = (cnt_ff == '0);
      stat.tethered   = built_ff & teth_q;
      stat.need_clamp = (sroot_ff > {1'b0, lim_ff});
      stat.out_busy   = rsp_valid_ff & ~rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

/* design/cloth_tether_constraint.sv */
// ----------------------------------------------------------------------------
// cloth_tether_constraint: long-range attachment constraint for cloth
// Keeps per-vertex rest and predicted positions, builds tethers to pinned
// roots and pulls predicted positions back inside their tether sphere.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat: tuser is the function (load rest vertex,
//   build tethers, write predicted position, solve). Load and predict give no
//   response beat; build gives one beat of kind 0, solve one beat of kind 1
//   with the corrected position and a clamped flag.
//   csr_* writes the tether scale (unsigned Q8.8); csr_ready is always high.
//   Write it only while no command is in flight.
// Sequencing (one command at a time; a new beat is accepted only while idle):
//   load, predict: a single table write, then idle again.
//   solve: a pinned or untethered vertex is emitted unchanged; otherwise the
//   distance to the root takes the 33-step square root, and a position that
//   is pulled back also takes the 32-step divider.
//   build: all 1024 vertices are visited; a tethered vertex walks its chain
//   to the root, one square root per segment walked.
// Reset: scale returns to 1.0 and every vertex counts as untethered until the
//   first build. Tables hold no reset value.
// Stall: a finished response waits in the output register; the next command
//   is accepted meanwhile and only its own response waits for the register.
// ----------------------------------------------------------------------------
module cloth_tether_constraint (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // vertex, pos_x, pos_y, pos_z, parent, has_parent, fixed
   input  logic [ctc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func
   input  logic [ctc_pkg::FUNC_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_vertex, out_x, out_y, out_z, clamped
   output logic [ctc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ctc_pkg::SCALE_W-1:0]      csr_data
);
   import ctc_pkg::*;

   logic        take;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // scale register takes every write
   assign csr_ready = 1'b1;

   ctc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .take       (take),
      .cmd        (cmd),
      .stat       (stat)
   );

   ctc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
